@@ design/quaternion_pitch_roll_slew_filter_core_defines.svh @@
// Assertion macros used by the checker file of the pitch and roll filter.
`ifndef QUATERNION_PITCH_ROLL_SLEW_FILTER_CORE_DEFINES_SVH
`define QUATERNION_PITCH_ROLL_SLEW_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QPRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qprs: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QPRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qprs: next-cycle check failed");

`endif

@@ design/qprs_pkg.sv @@
// Shared types, widths, constants and the arctangent table of the pitch and roll filter.
`timescale 1ns / 1ps

package qprs_pkg;

  // Field widths
  localparam int QUAT_W     = 16;
  localparam int ANGLE_W    = 16;
  localparam int CFG_W      = 15;
  localparam int CFG_IDX_W  = 1;

  // Datapath widths
  localparam int PROD_W      = 2 * QUAT_W;     // one exact square or cross product
  localparam int PSUM_W      = PROD_W + 1;     // sum of two products
  localparam int SUM_W       = PROD_W + 2;     // atan2 operand
  localparam int CORD_W      = SUM_W + 2;      // CORDIC x/y with gain headroom
  localparam int ANGLE_ACC_W = 34;             // Q30 angle accumulator
  localparam int RAW_W       = ANGLE_W + 1;    // rounded angle before saturation
  localparam int DIFF_W      = RAW_W + 1;      // slew difference and candidates

  // Angle format and iteration defaults
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_BITS  = 12;
  localparam int ATAN_TABLE_LEN   = 24;
  localparam int ATAN_IDX_W       = $clog2(ATAN_TABLE_LEN);
  localparam int ATAN_W           = 30;
  localparam int ROUND_SHIFT      = 30 - ANGLE_FRAC_BITS;

  localparam logic signed [ANGLE_ACC_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANGLE_ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANGLE_ACC_W-1:0] ROUND_BIAS  =
    ANGLE_ACC_W'(longint'(1) << (ROUND_SHIFT - 1));
  localparam logic signed [ANGLE_ACC_W-1:0] PITCH_BIAS  = ROUND_BIAS - HALF_PI_Q30;

  // Register reset values
  localparam logic [CFG_W-1:0] JUMP_THRESHOLD_RST = 15'd410;
  localparam logic [CFG_W-1:0] SLEW_STEP_RST      = 15'd41;

  // Angle lanes
  localparam int ANG_PITCH = 0;
  localparam int ANG_ROLL  = 1;
  localparam int NUM_ANG   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JUMP_THRESHOLD = 1'b0,
    CFG_SLEW_STEP      = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_COMB,
    ST_START,
    ST_CORD,
    ST_ROUND,
    ST_SLEW,
    ST_WRITE
  } state_e;

  // Status of one CORDIC lane toward the sequencer
  typedef struct packed {
    logic                          done;
    logic signed [ANGLE_ACC_W-1:0] angle;
  } cord_stat_t;

  // atan(2^-i) in Q30 radians
  function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'h3243F6A8;
      5'd1:    v = 30'h1DAC6705;
      5'd2:    v = 30'h0FADBAFC;
      5'd3:    v = 30'h07F56EA6;
      5'd4:    v = 30'h03FEAB76;
      5'd5:    v = 30'h01FFD55B;
      5'd6:    v = 30'h00FFFAAA;
      5'd7:    v = 30'h007FFF55;
      5'd8:    v = 30'h003FFFEA;
      5'd9:    v = 30'h001FFFFD;
      5'd10:   v = 30'h000FFFFF;
      5'd11:   v = 30'h0007FFFF;
      5'd12:   v = 30'h0003FFFF;
      5'd13:   v = 30'h0001FFFF;
      5'd14:   v = 30'h0000FFFF;
      5'd15:   v = 30'h00007FFF;
      5'd16:   v = 30'h00003FFF;
      5'd17:   v = 30'h00001FFF;
      5'd18:   v = 30'h00000FFF;
      5'd19:   v = 30'h000007FF;
      5'd20:   v = 30'h000003FF;
      5'd21:   v = 30'h000001FF;
      5'd22:   v = 30'h000000FF;
      5'd23:   v = 30'h0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ design/qprs_if.sv @@
// Request channels of the pitch and roll filter: quaternion in, angles out, register writes.
`timescale 1ns / 1ps

interface qprs_quat_if;
  logic                              valid;
  logic                              ready;
  logic signed [qprs_pkg::QUAT_W-1:0] quat_w;
  logic signed [qprs_pkg::QUAT_W-1:0] quat_x;
  logic signed [qprs_pkg::QUAT_W-1:0] quat_y;
  logic signed [qprs_pkg::QUAT_W-1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

interface qprs_angle_if;
  logic                               valid;
  logic                               ready;
  logic signed [qprs_pkg::ANGLE_W-1:0] pitch_out;
  logic signed [qprs_pkg::ANGLE_W-1:0] roll_out;

  modport source (output valid, output pitch_out, output roll_out, input ready);
  modport sink   (input valid, input pitch_out, input roll_out, output ready);
endinterface

interface qprs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [qprs_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [qprs_pkg::CFG_W-1:0]      reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

@@ design/qprs_cordic.sv @@
// Vectoring CORDIC lane: atan2(y, x) in Q30, one micro-rotation per cycle.
`timescale 1ns / 1ps

module qprs_cordic #(
  parameter int CORDIC_STEPS = qprs_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [qprs_pkg::SUM_W-1:0]      y_i,
  input  logic signed [qprs_pkg::SUM_W-1:0]      x_i,
  output qprs_pkg::cord_stat_t                   stat_o
);
  import qprs_pkg::*;

  localparam int IterW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IterW-1:0] LastIter = IterW'(CORDIC_STEPS - 1);

  logic signed [CORD_W-1:0]      x_q, x_d, y_q, y_d;
  logic signed [CORD_W-1:0]      x_ext, y_ext, dx, dy;
  logic signed [ANGLE_ACC_W-1:0] z_q, z_d, atan_ext;
  logic [IterW-1:0]              iter_q, iter_d;
  logic                          busy_q, busy_d;
  logic                          zero_q, zero_d;

  assign x_ext = {{(CORD_W-SUM_W){x_i[SUM_W-1]}}, x_i};
  assign y_ext = {{(CORD_W-SUM_W){y_i[SUM_W-1]}}, y_i};

  // Shifted cross terms and table angle for the current iteration
  assign dx       = y_q >>> iter_q;
  assign dy       = x_q >>> iter_q;
  assign atan_ext = {{(ANGLE_ACC_W-ATAN_W){1'b0}}, atan_q30(ATAN_IDX_W'(iter_q))};

  // Load operands, fold the left half plane, then rotate toward y = 0
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    iter_d = iter_q;
    busy_d = busy_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      zero_d = (x_i == '0) && (y_i == '0);
      if (x_i[SUM_W-1]) begin
        x_d = -x_ext;
        y_d = -y_ext;
        z_d = y_i[SUM_W-1] ? -PI_Q30 : PI_Q30;
      end else begin
        x_d = x_ext;
        y_d = y_ext;
        z_d = '0;
      end
    end else if (busy_q) begin
      if (!y_q[CORD_W-1]) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        if (!zero_q) begin
          z_d = z_q + atan_ext;
        end
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        if (!zero_q) begin
          z_d = z_q - atan_ext;
        end
      end
      iter_d = iter_q + 1'b1;
      if (iter_q == LastIter) begin
        busy_d = 1'b0;
        iter_d = '0;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  // Advance the rotation registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  assign stat_o.done  = busy_q && (iter_q == LastIter);
  assign stat_o.angle = z_q;

endmodule

@@ design/quaternion_pitch_roll_slew_filter_core.sv @@
// Top level of the quaternion to pitch and roll filter with slew limiting.
`timescale 1ns / 1ps

// Takes one quaternion (w, x, y, z, signed Q1.14) per request and returns one
// request with filtered pitch and roll in signed Q3.12 radians. Raw pitch is
// atan2(w2-x2-y2+z2, 2(yz+wx)) - pi/2 and raw roll is atan2(2(xz-wy), w2-x2+y2-z2);
// each raw angle is compared with the last value sent: a jump above
// jump_threshold moves the held value by slew_step toward it, an equal or smaller
// one is taken as is, and the result saturates to 16 bits. The held angles reset to
// zero. Each quaternion passes through the bit-serial multipliers that form the
// eight products, the combining of the operands, the two vectoring CORDIC lanes
// (one micro-rotation a cycle), then rounding, slew and write-back. A new
// quaternion is taken while the previous result still waits at the output
// register; the write-back waits only if that result has not been taken by
// then. Registers (index 0 jump_threshold, index 1 slew_step) are written any
// time the block is idle and are always ready.
module quaternion_pitch_roll_slew_filter_core #(
  parameter int CORDIC_STEPS = qprs_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  qprs_quat_if.sink     in_i,
  qprs_angle_if.source  out_o,
  qprs_cfg_if.sink      cfg_i
);
  import qprs_pkg::*;

  localparam int NumOps  = 4;
  localparam int NumProd = 8;
  localparam int BitCntW = $clog2(QUAT_W);
  localparam logic [BitCntW-1:0] LastBit = BitCntW'(QUAT_W - 1);

  // Operand index per input component
  localparam int OpW = 0;
  localparam int OpX = 1;
  localparam int OpY = 2;
  localparam int OpZ = 3;

  // Product lanes: multiplicand and multiplier operand of each
  localparam int PWw = 0;
  localparam int PXx = 1;
  localparam int PYy = 2;
  localparam int PZz = 3;
  localparam int PYz = 4;
  localparam int PWx = 5;
  localparam int PXz = 6;
  localparam int PWy = 7;
  localparam int McSel [NumProd] = '{OpW, OpX, OpY, OpZ, OpY, OpW, OpX, OpW};
  localparam int MpSel [NumProd] = '{OpW, OpX, OpY, OpZ, OpZ, OpX, OpZ, OpY};

  localparam logic signed [DIFF_W-1:0] SatMax = DIFF_W'((1 << (ANGLE_W - 1)) - 1);
  localparam logic signed [DIFF_W-1:0] SatMin = -SatMax - DIFF_W'(1);

  state_e state_q, state_d;

  // Configuration
  logic [CFG_W-1:0] thr_q, step_q;

  // Bit-serial multipliers
  logic signed [PROD_W-1:0] mcand_q [NumOps];
  logic        [QUAT_W-1:0] mplier_q [NumOps];
  logic signed [PROD_W-1:0] pp [NumProd];
  logic signed [PROD_W-1:0] prod_q [NumProd];
  logic signed [PROD_W-1:0] prod_d [NumProd];
  logic [BitCntW-1:0]       bit_cnt_q;
  logic                     last_bit;

  // Operand sums
  logic signed [PSUM_W-1:0] s_wz_q, s_xy_q, s_wy_q, s_xz_q, t_pd_q, t_rn_q;
  logic signed [SUM_W-1:0]  p_num_q, p_den_q, r_num_q, r_den_q;

  // CORDIC lanes
  logic       cord_start;
  cord_stat_t cord_stat [NUM_ANG];

  // Rounding and slew
  logic signed [ANGLE_ACC_W-1:0] biased [NUM_ANG];
  logic signed [ANGLE_ACC_W-1:0] shifted [NUM_ANG];
  logic signed [RAW_W-1:0]       raw_q [NUM_ANG];
  logic signed [DIFF_W-1:0]      raw_ext [NUM_ANG];
  logic signed [DIFF_W-1:0]      held_ext [NUM_ANG];
  logic signed [DIFF_W-1:0]      diff_q [NUM_ANG];
  logic signed [DIFF_W-1:0]      up_q [NUM_ANG];
  logic signed [DIFF_W-1:0]      dn_q [NUM_ANG];
  logic        [DIFF_W-1:0]      mag [NUM_ANG];
  logic signed [DIFF_W-1:0]      pick [NUM_ANG];
  logic signed [ANGLE_W-1:0]     held_new [NUM_ANG];
  logic signed [ANGLE_W-1:0]     held_q [NUM_ANG];
  logic signed [DIFF_W-1:0]      step_ext;
  logic        [DIFF_W-1:0]      thr_ext;

  logic in_acc, out_free, out_valid_q, out_valid_d;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign last_bit = (bit_cnt_q == LastBit);

  // Sequence one quaternion through multiply, combine, rotate and filter
  always_comb begin
    state_d    = state_q;
    cord_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (last_bit) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM:   state_d = ST_COMB;
      ST_COMB:  state_d = ST_START;
      ST_START: begin
        cord_start = 1'b1;
        state_d    = ST_CORD;
      end
      ST_CORD: begin
        if (cord_stat[ANG_PITCH].done && cord_stat[ANG_ROLL].done) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: state_d = ST_SLEW;
      ST_SLEW:  state_d = ST_WRITE;
      ST_WRITE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // Take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= JUMP_THRESHOLD_RST;
      step_q <= SLEW_STEP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.reg_index))
        CFG_JUMP_THRESHOLD: thr_q  <= cfg_i.reg_data;
        CFG_SLEW_STEP:      step_q <= cfg_i.reg_data;
        default: ;
      endcase
    end
  end

  // Add one partial product per lane; the sign bit of the multiplier subtracts
  always_comb begin
    for (int k = 0; k < NumProd; k++) begin
      pp[k]     = mplier_q[MpSel[k]][0] ? mcand_q[McSel[k]] : '0;
      prod_d[k] = last_bit ? (prod_q[k] - pp[k]) : (prod_q[k] + pp[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
    end else if (in_acc) begin
      bit_cnt_q <= '0;
    end else if (state_q == ST_MUL) begin
      bit_cnt_q <= bit_cnt_q + 1'b1;
    end
  end

  // Load operands, then shift multiplicands up and multipliers down a bit a cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mcand_q[OpW]  <= {{(PROD_W-QUAT_W){in_i.quat_w[QUAT_W-1]}}, in_i.quat_w};
      mcand_q[OpX]  <= {{(PROD_W-QUAT_W){in_i.quat_x[QUAT_W-1]}}, in_i.quat_x};
      mcand_q[OpY]  <= {{(PROD_W-QUAT_W){in_i.quat_y[QUAT_W-1]}}, in_i.quat_y};
      mcand_q[OpZ]  <= {{(PROD_W-QUAT_W){in_i.quat_z[QUAT_W-1]}}, in_i.quat_z};
      mplier_q[OpW] <= in_i.quat_w;
      mplier_q[OpX] <= in_i.quat_x;
      mplier_q[OpY] <= in_i.quat_y;
      mplier_q[OpZ] <= in_i.quat_z;
      for (int k = 0; k < NumProd; k++) begin
        prod_q[k] <= '0;
      end
    end else if (state_q == ST_MUL) begin
      for (int j = 0; j < NumOps; j++) begin
        mcand_q[j]  <= mcand_q[j] <<< 1;
        mplier_q[j] <= mplier_q[j] >> 1;
      end
      for (int k = 0; k < NumProd; k++) begin
        prod_q[k] <= prod_d[k];
      end
    end
  end

  // Pair the products, then form the four atan2 operands
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      s_wz_q <= {prod_q[PWw][PROD_W-1], prod_q[PWw]} + {prod_q[PZz][PROD_W-1], prod_q[PZz]};
      s_xy_q <= {prod_q[PXx][PROD_W-1], prod_q[PXx]} + {prod_q[PYy][PROD_W-1], prod_q[PYy]};
      s_wy_q <= {prod_q[PWw][PROD_W-1], prod_q[PWw]} + {prod_q[PYy][PROD_W-1], prod_q[PYy]};
      s_xz_q <= {prod_q[PXx][PROD_W-1], prod_q[PXx]} + {prod_q[PZz][PROD_W-1], prod_q[PZz]};
      t_pd_q <= {prod_q[PYz][PROD_W-1], prod_q[PYz]} + {prod_q[PWx][PROD_W-1], prod_q[PWx]};
      t_rn_q <= {prod_q[PXz][PROD_W-1], prod_q[PXz]} - {prod_q[PWy][PROD_W-1], prod_q[PWy]};
    end
    if (state_q == ST_COMB) begin
      p_num_q <= {s_wz_q[PSUM_W-1], s_wz_q} - {s_xy_q[PSUM_W-1], s_xy_q};
      r_den_q <= {s_wy_q[PSUM_W-1], s_wy_q} - {s_xz_q[PSUM_W-1], s_xz_q};
      p_den_q <= {t_pd_q, 1'b0};
      r_num_q <= {t_rn_q, 1'b0};
    end
  end

  qprs_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .y_i     (p_num_q),
    .x_i     (p_den_q),
    .stat_o  (cord_stat[ANG_PITCH])
  );

  qprs_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .y_i     (r_num_q),
    .x_i     (r_den_q),
    .stat_o  (cord_stat[ANG_ROLL])
  );

  assign step_ext = {{(DIFF_W-CFG_W){1'b0}}, step_q};
  assign thr_ext  = {{(DIFF_W-CFG_W){1'b0}}, thr_q};

  // Round Q30 to output units (pitch also drops pi/2), then pick the new held value
  always_comb begin
    for (int a = 0; a < NUM_ANG; a++) begin
      biased[a]   = cord_stat[a].angle + ((a == ANG_PITCH) ? PITCH_BIAS : ROUND_BIAS);
      shifted[a]  = biased[a] >>> ROUND_SHIFT;
      raw_ext[a]  = {raw_q[a][RAW_W-1], raw_q[a]};
      held_ext[a] = {{(DIFF_W-ANGLE_W){held_q[a][ANGLE_W-1]}}, held_q[a]};
      mag[a]      = diff_q[a][DIFF_W-1] ? $unsigned(-diff_q[a]) : $unsigned(diff_q[a]);
      if (mag[a] > thr_ext) begin
        pick[a] = diff_q[a][DIFF_W-1] ? dn_q[a] : up_q[a];
      end else begin
        pick[a] = raw_ext[a];
      end
      if (pick[a] > SatMax) begin
        held_new[a] = SatMax[ANGLE_W-1:0];
      end else if (pick[a] < SatMin) begin
        held_new[a] = SatMin[ANGLE_W-1:0];
      end else begin
        held_new[a] = pick[a][ANGLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NUM_ANG; a++) begin
      if (state_q == ST_ROUND) begin
        raw_q[a] <= shifted[a][RAW_W-1:0];
      end
      if (state_q == ST_SLEW) begin
        diff_q[a] <= raw_ext[a] - held_ext[a];
        up_q[a]   <= held_ext[a] + step_ext;
        dn_q[a]   <= held_ext[a] - step_ext;
      end
    end
  end

  // Write back the held angles into the output register once it is free
  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == ST_WRITE) && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int a = 0; a < NUM_ANG; a++) begin
        held_q[a] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if ((state_q == ST_WRITE) && out_free) begin
        for (int a = 0; a < NUM_ANG; a++) begin
          held_q[a] <= held_new[a];
        end
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pitch_out = held_q[ANG_PITCH];
  assign out_o.roll_out  = held_q[ANG_ROLL];

endmodule

@@ design/qprs_checker.sv @@
// Port-level checker of the pitch and roll filter and its bind to the top level.
`timescale 1ns / 1ps
`include "quaternion_pitch_roll_slew_filter_core_defines.svh"

module qprs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [qprs_pkg::ANGLE_W-1:0] pitch_i,
  input logic signed [qprs_pkg::ANGLE_W-1:0] roll_i
);

  // A pending result stays offered until taken
  `QPRS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // A stalled result keeps its angles
  `QPRS_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(pitch_i) && $stable(roll_i))

  // One quaternion at a time: the input closes right after a request
  `QPRS_ASSERT_NXT(a_in_busy, in_valid_i && in_ready_i, !in_ready_i)

  // Held angles move only together with a new result being offered
  `QPRS_ASSERT_IMP(a_held_quiet, !out_valid_i, $stable(pitch_i) && $stable(roll_i))

endmodule

bind quaternion_pitch_roll_slew_filter_core qprs_checker u_qprs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pitch_i     (out_o.pitch_out),
  .roll_i      (out_o.roll_out)
);
